### src/nfcs_pkg.sv
`timescale 1ns / 1ps
package nfcs_pkg;

  localparam int AddressBitsDefault = 19;
  localparam int MaxAddrW  = 24;
  localparam int BusAddrW  = 19;
  localparam int TicksW    = 24;
  localparam int SetupW    = 16;
  localparam int DacW      = 12;
  localparam int ByteW     = 8;
  localparam int CfgIdxW   = 3;
  localparam int StepW     = 3;

  typedef enum logic [1:0] {
    CmdRead        = 2'd0,
    CmdProgram     = 2'd1,
    CmdSectorErase = 2'd2,
    CmdChipErase   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KindWrite  = 2'd0,
    KindRead   = 2'd1,
    KindSupply = 2'd2,
    KindWait   = 2'd3
  } kind_e;

  localparam logic [CfgIdxW-1:0] CfgWriteSetup  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgReadSettle  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgProgramWait = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSectorWait  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgChipWait    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgNominalCode = 3'd5;

  localparam logic [SetupW-1:0] WriteSetupReset  = 16'd16;
  localparam logic [SetupW-1:0] ReadSettleReset  = 16'd16;
  localparam logic [TicksW-1:0] ProgramWaitReset = 24'd1000;
  localparam logic [TicksW-1:0] SectorWaitReset  = 24'd1250000;
  localparam logic [TicksW-1:0] ChipWaitReset    = 24'd5000000;
  localparam logic [DacW-1:0]   NominalCodeReset = 12'd3103;

  localparam logic [BusAddrW-1:0] UnlockA = 19'h05555;
  localparam logic [BusAddrW-1:0] UnlockB = 19'h02AAA;
  localparam logic [ByteW-1:0] DataUnlock1  = 8'hAA;
  localparam logic [ByteW-1:0] DataUnlock2  = 8'h55;
  localparam logic [ByteW-1:0] DataProgram  = 8'hA0;
  localparam logic [ByteW-1:0] DataErase    = 8'h80;
  localparam logic [ByteW-1:0] DataSector   = 8'h30;
  localparam logic [ByteW-1:0] DataChip     = 8'h10;

  localparam logic [StepW-1:0] StepFirst = 3'd0;
  localparam logic [StepW-1:0] StepLast  = 3'd6;

  typedef struct packed {
    logic [SetupW-1:0] write_setup;
    logic [SetupW-1:0] read_settle;
    logic [TicksW-1:0] program_wait;
    logic [TicksW-1:0] sector_wait;
    logic [TicksW-1:0] chip_wait;
    logic [DacW-1:0]   nominal_code;
  } cfg_t;

  typedef struct packed {
    cmd_e               cmd;
    logic [StepW-1:0]   last_step;
    logic [MaxAddrW-1:0] addr;
    logic [ByteW-1:0]   data;
    logic [DacW-1:0]    code;
    logic [ByteW-1:0]   rdv;
  } req_t;

  typedef struct packed {
    kind_e               kind;
    logic [BusAddrW-1:0] bus_addr;
    logic [ByteW-1:0]    data;
    logic [DacW-1:0]     dac;
    logic [TicksW-1:0]   ticks;
    logic [ByteW-1:0]    rd;
    logic                last;
  } res_t;

endpackage

### src/nfcs_front.sv
`timescale 1ns / 1ps
module nfcs_front #(
  parameter int AddressBits = nfcs_pkg::AddressBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic [1:0]             command_i,
  input  logic [AddressBits-1:0] address_i,
  input  logic [7:0]             write_data_i,
  input  logic [11:0]            supply_code_i,
  input  logic [7:0]             bus_read_value_i,
  output logic                   req_valid_o,
  output nfcs_pkg::req_t         req_o,
  input  logic                   req_take_i
);
  import nfcs_pkg::*;

  localparam int Depth = 2;

  req_t       entry_q [Depth];
  req_t       req_in;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       accept;

  always_comb begin
    req_in.cmd       = cmd_e'(command_i);
    req_in.last_step = (cmd_e'(command_i) == CmdRead) ? StepFirst : StepLast;
    req_in.addr      = MaxAddrW'(address_i);
    req_in.data      = write_data_i;
    req_in.code      = supply_code_i;
    req_in.rdv       = bus_read_value_i;
  end

  assign full        = (count_q == 2'(Depth));
  assign accept      = push && !full;
  assign req_valid_o = (count_q != 2'd0);
  assign req_o       = entry_q[rd_ptr_q];

  assign wr_ptr_d = accept ? ~wr_ptr_q : wr_ptr_q;
  assign rd_ptr_d = req_take_i ? ~rd_ptr_q : rd_ptr_q;
  assign count_d  = count_q + {1'b0, accept} - {1'b0, req_take_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q[wr_ptr_q] <= req_in;
    end
  end

  a_take_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_take_i |-> count_q != 2'd0)
    else $error("queue read while empty");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'(Depth))
    else $error("queue count overflow");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full && !req_take_i |=> full)
    else $error("queue left full without a read");

endmodule

### src/nfcs_back.sv
`timescale 1ns / 1ps
module nfcs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  nfcs_pkg::cfg_t cfg_i,
  input  logic           req_valid_i,
  input  nfcs_pkg::req_t req_i,
  output logic           req_take_o,
  output logic           empty,
  input  logic           pop,
  output nfcs_pkg::res_t res_o
);
  import nfcs_pkg::*;

  logic [StepW-1:0] step_q, step_d;
  logic             out_valid_q, out_valid_d;
  logic             emit;
  res_t             res_d;
  res_t             res_q;

  always_comb begin
    res_d.kind     = KindWrite;
    res_d.bus_addr = UnlockA;
    res_d.data     = DataUnlock1;
    res_d.dac      = '0;
    res_d.ticks    = TicksW'(cfg_i.write_setup);
    res_d.rd       = '0;
    res_d.last     = (step_q == req_i.last_step);
    if (req_i.cmd == CmdRead) begin
      res_d.kind     = KindRead;
      res_d.bus_addr = req_i.addr[BusAddrW-1:0];
      res_d.data     = '0;
      res_d.ticks    = TicksW'(cfg_i.read_settle);
      res_d.rd       = req_i.rdv;
    end else if (req_i.cmd == CmdProgram) begin
      case (step_q)
        3'd0: ;
        3'd1: begin
          res_d.bus_addr = UnlockB;
          res_d.data     = DataUnlock2;
        end
        3'd2: res_d.data = DataProgram;
        3'd3: begin
          res_d.kind     = KindSupply;
          res_d.bus_addr = '0;
          res_d.data     = '0;
          res_d.dac      = req_i.code;
          res_d.ticks    = '0;
        end
        3'd4: begin
          res_d.bus_addr = req_i.addr[BusAddrW-1:0];
          res_d.data     = req_i.data;
        end
        3'd5: begin
          res_d.kind     = KindWait;
          res_d.bus_addr = '0;
          res_d.data     = '0;
          res_d.ticks    = cfg_i.program_wait;
        end
        default: begin
          res_d.kind     = KindSupply;
          res_d.bus_addr = '0;
          res_d.data     = '0;
          res_d.dac      = cfg_i.nominal_code;
          res_d.ticks    = '0;
        end
      endcase
    end else begin
      case (step_q)
        3'd0: ;
        3'd1: begin
          res_d.bus_addr = UnlockB;
          res_d.data     = DataUnlock2;
        end
        3'd2: res_d.data = DataErase;
        3'd3: ;
        3'd4: begin
          res_d.bus_addr = UnlockB;
          res_d.data     = DataUnlock2;
        end
        3'd5: begin
          if (req_i.cmd == CmdSectorErase) begin
            res_d.bus_addr = req_i.addr[BusAddrW-1:0];
            res_d.data     = DataSector;
          end else begin
            res_d.data = DataChip;
          end
        end
        default: begin
          res_d.kind     = KindWait;
          res_d.bus_addr = '0;
          res_d.data     = '0;
          res_d.ticks    = (req_i.cmd == CmdSectorErase) ? cfg_i.sector_wait
                                                         : cfg_i.chip_wait;
        end
      endcase
    end
  end

  assign emit       = req_valid_i && (!out_valid_q || pop);
  assign req_take_o = emit && res_d.last;
  assign step_d     = req_take_o ? StepFirst : (emit ? step_q + 3'd1 : step_q);
  assign out_valid_d = emit || (out_valid_q && !pop);
  assign empty      = !out_valid_q;
  assign res_o      = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= StepFirst;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res_d;
    end
  end

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= StepLast)
    else $error("step counter out of range");

  a_mid_request_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != StepFirst |-> req_valid_i && req_i.cmd != CmdRead)
    else $error("request lost during expansion");

  a_step_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !res_d.last |=> step_q == $past(step_q) + 3'd1)
    else $error("step did not advance");

endmodule

### src/parallel_nor_flash_command_sequencer.sv
// Expands flash requests (read, byte program, sector erase, chip erase) into
// the ordered bus cycles of a JEDEC style parallel NOR flash: write strobes,
// read strobes, supply DAC settings and timed waits, one word per clock on a
// queue-style result port when pop does not hold it back. A read gives one
// word, every other request seven; the back-end step counter, which emits one
// bus cycle per clock unless a word waits unpopped, sets that rate. A two-word
// request queue lets new requests be pushed while a request is expanding.
// The tick values in each word are carried to the downstream bus timer.
// Configuration writes belong in idle periods only.
`timescale 1ns / 1ps
module parallel_nor_flash_command_sequencer #(
  parameter int AddressBits = nfcs_pkg::AddressBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_index_i,
  input  logic [23:0]            cfg_data_i,
  input  logic                   push,
  output logic                   full,
  input  logic [1:0]             command_i,
  input  logic [AddressBits-1:0] address_i,
  input  logic [7:0]             write_data_i,
  input  logic [11:0]            supply_code_i,
  input  logic [7:0]             bus_read_value_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [1:0]             cycle_kind_o,
  output logic [18:0]            bus_address_o,
  output logic [7:0]             bus_data_o,
  output logic [11:0]            dac_code_o,
  output logic [23:0]            wait_ticks_o,
  output logic [7:0]             read_data_o,
  output logic                   last_o
);
  import nfcs_pkg::*;

  cfg_t cfg_q;
  req_t req;
  res_t res;
  logic req_valid;
  logic req_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.write_setup  <= WriteSetupReset;
      cfg_q.read_settle  <= ReadSettleReset;
      cfg_q.program_wait <= ProgramWaitReset;
      cfg_q.sector_wait  <= SectorWaitReset;
      cfg_q.chip_wait    <= ChipWaitReset;
      cfg_q.nominal_code <= NominalCodeReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgWriteSetup:  cfg_q.write_setup  <= cfg_data_i[SetupW-1:0];
        CfgReadSettle:  cfg_q.read_settle  <= cfg_data_i[SetupW-1:0];
        CfgProgramWait: cfg_q.program_wait <= cfg_data_i[TicksW-1:0];
        CfgSectorWait:  cfg_q.sector_wait  <= cfg_data_i[TicksW-1:0];
        CfgChipWait:    cfg_q.chip_wait    <= cfg_data_i[TicksW-1:0];
        CfgNominalCode: cfg_q.nominal_code <= cfg_data_i[DacW-1:0];
        default: ;
      endcase
    end
  end

  nfcs_front #(
    .AddressBits(AddressBits)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .command_i       (command_i),
    .address_i       (address_i),
    .write_data_i    (write_data_i),
    .supply_code_i   (supply_code_i),
    .bus_read_value_i(bus_read_value_i),
    .req_valid_o     (req_valid),
    .req_o           (req),
    .req_take_i      (req_take)
  );

  nfcs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .req_valid_i(req_valid),
    .req_i      (req),
    .req_take_o (req_take),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res)
  );

  assign cycle_kind_o  = res.kind;
  assign bus_address_o = res.bus_addr;
  assign bus_data_o    = res.data;
  assign dac_code_o    = res.dac;
  assign wait_ticks_o  = res.ticks;
  assign read_data_o   = res.rd;
  assign last_o        = res.last;

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
module tb;
  import nfcs_pkg::*;

  localparam int QuietLimit = 4000;
  localparam int TailCycles = 20;
  localparam int PhaseItems = 24;
  localparam logic [CfgIdxW-1:0] CfgNoRegLow  = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgNoRegHigh = 3'd7;
  localparam logic [BusAddrW-1:0] AddrTop = 19'h7FFFF;

  typedef struct {
    cmd_e                cmd;
    logic [BusAddrW-1:0] addr;
    logic [ByteW-1:0]    data;
    logic [DacW-1:0]     code;
    logic [ByteW-1:0]    rdv;
  } flash_req_t;

  class bus_cycle_scoreboard;
    cfg_t        regs;
    res_t        pending_cycles[$];
    int unsigned errors;

    function new();
      regs.write_setup  = WriteSetupReset;
      regs.read_settle  = ReadSettleReset;
      regs.program_wait = ProgramWaitReset;
      regs.sector_wait  = SectorWaitReset;
      regs.chip_wait    = ChipWaitReset;
      regs.nominal_code = NominalCodeReset;
      errors = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [TicksW-1:0] val);
      case (idx)
        CfgWriteSetup:  regs.write_setup  = val[SetupW-1:0];
        CfgReadSettle:  regs.read_settle  = val[SetupW-1:0];
        CfgProgramWait: regs.program_wait = val;
        CfgSectorWait:  regs.sector_wait  = val;
        CfgChipWait:    regs.chip_wait    = val;
        CfgNominalCode: regs.nominal_code = val[DacW-1:0];
        default: ;
      endcase
    endfunction

    function void add_cycle(kind_e kind, logic [BusAddrW-1:0] a, logic [ByteW-1:0] d,
                            logic [DacW-1:0] dac, logic [TicksW-1:0] ticks,
                            logic [ByteW-1:0] rd, logic last);
      res_t w;
      w.kind     = kind;
      w.bus_addr = a;
      w.data     = d;
      w.dac      = dac;
      w.ticks    = ticks;
      w.rd       = rd;
      w.last     = last;
      pending_cycles.push_back(w);
    endfunction

    function void add_write(logic [BusAddrW-1:0] a, logic [ByteW-1:0] d);
      add_cycle(KindWrite, a, d, '0, TicksW'(regs.write_setup), '0, 1'b0);
    endfunction

    function void expand_request(flash_req_t r);
      if (r.cmd == CmdRead) begin
        add_cycle(KindRead, r.addr, '0, '0, TicksW'(regs.read_settle), r.rdv, 1'b1);
        return;
      end
      add_write(UnlockA, DataUnlock1);
      add_write(UnlockB, DataUnlock2);
      if (r.cmd == CmdProgram) begin
        add_write(UnlockA, DataProgram);
        add_cycle(KindSupply, '0, '0, r.code, '0, '0, 1'b0);
        add_write(r.addr, r.data);
        add_cycle(KindWait, '0, '0, '0, regs.program_wait, '0, 1'b0);
        add_cycle(KindSupply, '0, '0, regs.nominal_code, '0, '0, 1'b1);
        return;
      end
      add_write(UnlockA, DataErase);
      add_write(UnlockA, DataUnlock1);
      add_write(UnlockB, DataUnlock2);
      if (r.cmd == CmdSectorErase) begin
        add_write(r.addr, DataSector);
        add_cycle(KindWait, '0, '0, '0, regs.sector_wait, '0, 1'b1);
      end else begin
        add_write(UnlockA, DataChip);
        add_cycle(KindWait, '0, '0, '0, regs.chip_wait, '0, 1'b1);
      end
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    task compare(string name, logic [TicksW-1:0] got, logic [TicksW-1:0] want);
      if (got !== want)
        report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    task check_cycle(res_t got);
      res_t want;
      if (pending_cycles.size() == 0) begin
        report($sformatf("unexpected word kind=%0d addr=0x%0h", got.kind, got.bus_addr));
        return;
      end
      want = pending_cycles.pop_front();
      compare("cycle_kind", TicksW'(got.kind), TicksW'(want.kind));
      compare("bus_address", TicksW'(got.bus_addr), TicksW'(want.bus_addr));
      compare("bus_data", TicksW'(got.data), TicksW'(want.data));
      compare("dac_code", TicksW'(got.dac), TicksW'(want.dac));
      compare("wait_ticks", got.ticks, want.ticks);
      compare("read_data", TicksW'(got.rd), TicksW'(want.rd));
      compare("last", TicksW'(got.last), TicksW'(want.last));
    endtask

    task final_check();
      if (pending_cycles.size() != 0)
        report($sformatf("%0d words never arrived", pending_cycles.size()));
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [TicksW-1:0]   cfg_data_i = '0;
  logic                push = 1'b0;
  logic                full;
  logic [1:0]          command_i = '0;
  logic [BusAddrW-1:0] address_i = '0;
  logic [ByteW-1:0]    write_data_i = '0;
  logic [DacW-1:0]     supply_code_i = '0;
  logic [ByteW-1:0]    bus_read_value_i = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [1:0]          cycle_kind_o;
  logic [18:0]         bus_address_o;
  logic [7:0]          bus_data_o;
  logic [11:0]         dac_code_o;
  logic [23:0]         wait_ticks_o;
  logic [7:0]          read_data_o;
  logic                last_o;

  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  bus_cycle_scoreboard sb = new();

  parallel_nor_flash_command_sequencer i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .push             (push),
    .full             (full),
    .command_i        (command_i),
    .address_i        (address_i),
    .write_data_i     (write_data_i),
    .supply_code_i    (supply_code_i),
    .bus_read_value_i (bus_read_value_i),
    .empty            (empty),
    .pop              (pop),
    .cycle_kind_o     (cycle_kind_o),
    .bus_address_o    (bus_address_o),
    .bus_data_o       (bus_data_o),
    .dac_code_o       (dac_code_o),
    .wait_ticks_o     (wait_ticks_o),
    .read_data_o      (read_data_o),
    .last_o           (last_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin : result_side
    res_t got;
    if (rst_ni) begin
      if (pop && !empty) begin
        got.kind     = kind_e'(cycle_kind_o);
        got.bus_addr = bus_address_o;
        got.data     = bus_data_o;
        got.dac      = dac_code_o;
        got.ticks    = wait_ticks_o;
        got.rd       = read_data_o;
        got.last     = last_o;
        sb.check_cycle(got);
      end
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("ERROR @%0t: no word moved for %0d cycles", $time, QuietLimit);
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic flash_req_t make_req(cmd_e cmd, logic [BusAddrW-1:0] a,
                                          logic [ByteW-1:0] d, logic [DacW-1:0] code,
                                          logic [ByteW-1:0] rdv);
    flash_req_t r;
    r.cmd  = cmd;
    r.addr = a;
    r.data = d;
    r.code = code;
    r.rdv  = rdv;
    return r;
  endfunction

  function automatic flash_req_t random_req();
    flash_req_t r;
    int unsigned pick;
    r = make_req(cmd_e'($urandom_range(3)), BusAddrW'($urandom()), ByteW'($urandom()),
                 DacW'($urandom()), ByteW'($urandom()));
    pick = $urandom_range(9);
    if (pick == 0) r.addr = '0;
    else if (pick == 1) r.addr = AddrTop;
    if ($urandom_range(4) == 0) r.code = sb.regs.nominal_code;
    return r;
  endfunction

  task automatic send_request(input flash_req_t r);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push             <= 1'b1;
    command_i        <= r.cmd;
    address_i        <= r.addr;
    write_data_i     <= r.data;
    supply_code_i    <= r.code;
    bus_read_value_i <= r.rdv;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.expand_request(r);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending_cycles.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TicksW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic load_config(input logic [TicksW-1:0] setup, settle, prog, sector, chip,
                             nominal);
    write_reg(CfgWriteSetup, setup);
    write_reg(CfgReadSettle, settle);
    write_reg(CfgProgramWait, prog);
    write_reg(CfgSectorWait, sector);
    write_reg(CfgChipWait, chip);
    write_reg(CfgNominalCode, nominal);
    // unmapped indexes must leave every register alone
    write_reg(CfgNoRegLow, TicksW'($urandom()));
    write_reg(CfgNoRegHigh, TicksW'($urandom()));
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(make_req(CmdRead, '0, 8'h5A, 12'h123, 8'h00));
    send_request(make_req(CmdRead, AddrTop, 8'hA5, 12'hEDC, 8'hFF));
    send_request(make_req(CmdRead, 19'h55555, 8'h00, 12'h000, 8'hA5));
    send_request(make_req(CmdProgram, '0, 8'h00, 12'h000, 8'hFF));
    send_request(make_req(CmdProgram, AddrTop, 8'hFF, 12'hFFF, 8'h00));
    send_request(make_req(CmdProgram, 19'h2AAAA, 8'h3C, NominalCodeReset, 8'h96));
    send_request(make_req(CmdSectorErase, '0, 8'hFF, 12'hFFF, 8'hFF));
    send_request(make_req(CmdSectorErase, AddrTop, 8'h00, 12'h000, 8'h00));
    send_request(make_req(CmdChipErase, 19'h12345, 8'h81, 12'h801, 8'h7E));
    send_request(make_req(CmdChipErase, AddrTop, 8'hFF, 12'hFFF, 8'hFF));
    send_request(make_req(CmdRead, 19'h2AAAA, 8'hFF, 12'hFFF, 8'h5A));

    for (int p = 0; p < 5; p++) begin
      drain();
      case (p)
        0: begin
          load_config('1, '1, '1, '1, '1, '1);
          send_idle_pct = 0;
          pop_stall_pct = 0;
        end
        1: begin
          load_config('0, '0, '0, '0, '0, '0);
          send_idle_pct = 82;
          pop_stall_pct = 0;
        end
        2: begin
          load_config(TicksW'($urandom()), TicksW'($urandom()), TicksW'($urandom()),
                      TicksW'($urandom()), TicksW'($urandom()), TicksW'($urandom()));
          send_idle_pct = 0;
          pop_stall_pct = 82;
        end
        3: begin
          load_config(24'd1, 24'h00FFFF, TicksW'($urandom()), 24'hFFFFFF, 24'd0,
                      24'h000FFF);
          send_idle_pct = 17;
          pop_stall_pct = 17;
        end
        default: begin
          load_config(TicksW'($urandom()), TicksW'($urandom()), TicksW'($urandom()),
                      TicksW'($urandom()), TicksW'($urandom()), 24'd0);
          send_idle_pct = 0;
          pop_stall_pct = 0;
        end
      endcase
      repeat (PhaseItems) send_request(random_req());
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    sb.final_check();
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### parallel_nor_flash_command_sequencer.f
src/nfcs_pkg.sv
src/nfcs_front.sv
src/nfcs_back.sv
src/parallel_nor_flash_command_sequencer.sv
verif/tb.sv
